// ===== rtl/core/tcgr_pkg.sv =====
package tcgr_pkg;

    localparam int CMD_W       = 2;
    localparam int ROW_IN_W    = 5;
    localparam int COL_IN_W    = 7;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int FONT_ADDR_W = 12;
    localparam int FONT_BYTE_W = 8;
    localparam int FONT_DEPTH  = 4096;
    localparam int FONT_ROW_W  = 4;
    localparam int CELL_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int COLOUR_W    = 32;
    localparam int PIX_W       = 8;
    localparam int GLYPH_WIDTH = 8;

    // Pixel coordinates stay below 2^13 for every legal input.
    localparam int COORD_W     = 13;
    localparam int LINE_W      = 16;
    localparam int ORIGIN_W    = 12;
    localparam int PROD_W      = COORD_W + LINE_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CELL_W-1:0] CELL_RESET = 16'h1720;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FONT  = 2'd0,
        CMD_WRITE_CELL = 2'd1,
        CMD_RENDER     = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_8BPP   = 2'd0,
        MODE_RGB555 = 2'd1,
        MODE_RGB565 = 2'd2,
        MODE_32BPP  = 2'd3
    } t_depth;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_MODE  = 3'd0,
        CFG_FRAME_BASE  = 3'd1,
        CFG_LINE_BYTES  = 3'd2,
        CFG_ORIGIN_X    = 3'd3,
        CFG_ORIGIN_Y    = 3'd4,
        CFG_SCREEN_W    = 3'd5,
        CFG_SCREEN_H    = 3'd6,
        CFG_NONE        = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_BASE,
        ST_ROW
    } t_state;

    localparam logic [COLOUR_W-1:0] PALETTE [16] = '{
        32'h00000000, 32'h000000aa, 32'h0000aa00, 32'h0000aaaa,
        32'h00aa0000, 32'h00aa00aa, 32'h00aa5500, 32'h00aaaaaa,
        32'h00555555, 32'h005555ff, 32'h0055ff55, 32'h0055ffff,
        32'h00ff5555, 32'h00ff55ff, 32'h00ffff55, 32'h00ffffff
    };

    function automatic logic [COLOUR_W-1:0] pack_colour(input t_depth mode,
                                                        input logic [3:0] idx);
        logic [COLOUR_W-1:0] rgb;
        logic [COLOUR_W-1:0] res;
        rgb = PALETTE[idx];
        unique case (mode)
            MODE_8BPP: begin
                res = {28'd0, idx};
            end
            MODE_RGB555: begin
                res = ((rgb >> 9) & 32'h00007c00) | ((rgb >> 6) & 32'h000003e0)
                    | ((rgb >> 3) & 32'h0000001f);
            end
            MODE_RGB565: begin
                res = ((rgb >> 8) & 32'h0000f800) | ((rgb >> 5) & 32'h000007e0)
                    | ((rgb >> 3) & 32'h0000001f);
            end
            default: begin
                res = rgb;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/tcgr_req_if.sv =====
interface tcgr_req_if;
    logic                                valid;
    logic                                ready;
    logic [tcgr_pkg::CMD_W-1:0]          cmd;
    logic [tcgr_pkg::ROW_IN_W-1:0]       cell_row;
    logic [tcgr_pkg::COL_IN_W-1:0]       cell_col;
    logic [tcgr_pkg::CHAR_W-1:0]         char_code;
    logic [tcgr_pkg::ATTR_W-1:0]         attribute;
    logic [tcgr_pkg::FONT_ADDR_W-1:0]    font_address;
    logic [tcgr_pkg::FONT_BYTE_W-1:0]    font_byte;

    modport source (
        output valid, cmd, cell_row, cell_col, char_code, attribute, font_address, font_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_row, cell_col, char_code, attribute, font_address, font_byte,
        output ready
    );
endinterface

// ===== rtl/core/tcgr_res_if.sv =====
interface tcgr_res_if;
    logic                            valid;
    logic                            ready;
    logic [tcgr_pkg::ADDR_W-1:0]     row_address;
    logic [tcgr_pkg::PIX_W-1:0]      glyph_bits;
    logic [tcgr_pkg::PIX_W-1:0]      pixel_valid;
    logic [tcgr_pkg::COLOUR_W-1:0]   fore_value;
    logic [tcgr_pkg::COLOUR_W-1:0]   back_value;
    logic                            last_row;

    modport source (
        output valid, row_address, glyph_bits, pixel_valid, fore_value, back_value, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_address, glyph_bits, pixel_valid, fore_value, back_value, last_row,
        output ready
    );
endinterface

// ===== rtl/core/tcgr_ram.sv =====
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/text_cell_glyph_renderer.sv =====
// Text-mode character generator.
// Requests arrive on i_req (valid/ready). A font load writes one byte of the
// font memory and a cell write stores a character/attribute pair; each is
// written on acceptance and leaves the sequencer idle. A render of an
// in-range cell reads the cell, then the font, and drives GLYPH_HEIGHT result
// rows on o_res, one per cycle while the receiver keeps ready high; the first
// row passes through the ST_CELL and ST_BASE states and the result register.
// The sequencer does one multiply (line * line_bytes) for the first row and
// then steps the row address by line_bytes through one 32-bit adder for
// each further row. Renders of out-of-range cells and the unused command
// are taken and dropped. i_req.ready is high only while the sequencer is idle.
// After reset the cell memory is filled with a space in attribute 0x17, one
// entry per cycle, and no request is taken until every entry is written.
// Configuration writes are taken at any time.
// The font memory is not cleared; load every glyph before rendering it.
// A stall on o_res holds the result register and the font read data, and
// the sequencer waits without losing a row.
module text_cell_glyph_renderer #(
    parameter int TEXT_COLS    = 80,
    parameter int TEXT_ROWS    = 25,
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    tcgr_req_if.sink                             i_req,
    tcgr_res_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int CELLS   = TEXT_COLS * TEXT_ROWS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W   = $clog2(GLYPH_HEIGHT);
    localparam int FONT_AW = $clog2(tcgr_pkg::FONT_DEPTH);

    // Configuration registers
    tcgr_pkg::t_depth                  r_mode;
    logic [tcgr_pkg::ADDR_W-1:0]       r_frame_base;
    logic [tcgr_pkg::LINE_W-1:0]       r_line_bytes;
    logic [tcgr_pkg::ORIGIN_W-1:0]     r_origin_x;
    logic [tcgr_pkg::ORIGIN_W-1:0]     r_origin_y;
    logic [tcgr_pkg::COORD_W-1:0]      r_screen_w;
    logic [tcgr_pkg::COORD_W-1:0]      r_screen_h;

    // Sequencer
    tcgr_pkg::t_state                  r_state;
    tcgr_pkg::t_state                  n_state;
    logic [CELL_AW-1:0]                r_clr_addr;
    logic [ROW_W-1:0]                  r_row;
    logic [ROW_W-1:0]                  n_row;

    // Render working registers
    logic [tcgr_pkg::COORD_W-1:0]      r_y;
    logic [tcgr_pkg::COORD_W-1:0]      r_px;
    logic [tcgr_pkg::PROD_W-1:0]       r_prod;
    logic [tcgr_pkg::ADDR_W-1:0]       r_addr;
    logic [tcgr_pkg::CHAR_W-1:0]       r_ch;
    logic [tcgr_pkg::COLOUR_W-1:0]     r_fore;
    logic [tcgr_pkg::COLOUR_W-1:0]     r_back;
    logic [tcgr_pkg::PIX_W-1:0]        r_colmask;

    // Result register
    logic                              r_out_valid;
    logic [tcgr_pkg::ADDR_W-1:0]       r_out_addr;
    logic [tcgr_pkg::PIX_W-1:0]        r_out_bits;
    logic [tcgr_pkg::PIX_W-1:0]        r_out_mask;
    logic [tcgr_pkg::COLOUR_W-1:0]     r_out_fore;
    logic [tcgr_pkg::COLOUR_W-1:0]     r_out_back;
    logic                              r_out_last;

    // Memory controls
    logic                              cell_we;
    logic [CELL_AW-1:0]                cell_waddr;
    logic [tcgr_pkg::CELL_W-1:0]       cell_wdata;
    logic                              cell_re;
    logic [tcgr_pkg::CELL_W-1:0]       cell_rdata;
    logic                              font_we;
    logic                              font_re;
    logic [FONT_AW-1:0]                font_raddr;
    logic [tcgr_pkg::FONT_BYTE_W-1:0]  font_rdata;

    // Decoded request
    logic                              req_fire;
    logic                              in_range;
    logic [CELL_AW-1:0]                req_cell_idx;
    tcgr_pkg::t_cmd                    req_cmd;
    logic                              out_free;
    logic                              row_load;
    logic                              row_last;
    logic                              clr_last;
    logic [tcgr_pkg::COORD_W-1:0]      req_y0;
    logic [tcgr_pkg::COORD_W-1:0]      req_px;
    logic [tcgr_pkg::ADDR_W-1:0]       px_bytes;
    logic [tcgr_pkg::PIX_W-1:0]        colmask;
    logic                              row_visible;

    assign req_cmd      = tcgr_pkg::t_cmd'(i_req.cmd);
    assign req_fire     = i_req.valid && i_req.ready;
    assign in_range     = ({3'd0, i_req.cell_row} < 8'(TEXT_ROWS))
                       && ({2'd0, i_req.cell_col} < 9'(TEXT_COLS));
    assign req_cell_idx = CELL_AW'(int'(i_req.cell_row) * TEXT_COLS + int'(i_req.cell_col));
    assign req_y0       = tcgr_pkg::COORD_W'(r_origin_y)
                        + tcgr_pkg::COORD_W'(int'(i_req.cell_row) * GLYPH_HEIGHT);
    assign req_px       = tcgr_pkg::COORD_W'(r_origin_x)
                        + tcgr_pkg::COORD_W'({i_req.cell_col, 3'd0});
    assign out_free     = !r_out_valid || o_res.ready;
    assign row_last     = (r_row == ROW_W'(GLYPH_HEIGHT - 1));
    assign clr_last     = (r_clr_addr == CELL_AW'(CELLS - 1));
    assign row_load     = (r_state == tcgr_pkg::ST_ROW) && out_free;

    // Horizontal byte offset of the cell's left pixel
    always_comb begin
        unique case (r_mode)
            tcgr_pkg::MODE_8BPP:   px_bytes = 32'(r_px);
            tcgr_pkg::MODE_32BPP:  px_bytes = 32'(r_px) << 2;
            default:               px_bytes = 32'(r_px) << 1;
        endcase
    end

    // Column clip: fixed for the whole cell, so build it once
    always_comb begin
        for (int c = 0; c < tcgr_pkg::GLYPH_WIDTH; c++) begin
            colmask[tcgr_pkg::GLYPH_WIDTH-1-c] =
                ((14'(r_px) + 14'(c)) < 14'(r_screen_w));
        end
    end

    assign row_visible = (r_y < r_screen_h);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcgr_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = tcgr_pkg::ST_IDLE;
                end
            end
            tcgr_pkg::ST_IDLE: begin
                if (req_fire && req_cmd == tcgr_pkg::CMD_RENDER && in_range) begin
                    n_state = tcgr_pkg::ST_CELL;
                end
            end
            tcgr_pkg::ST_CELL: begin
                n_state = tcgr_pkg::ST_BASE;
            end
            tcgr_pkg::ST_BASE: begin
                n_state = tcgr_pkg::ST_ROW;
            end
            tcgr_pkg::ST_ROW: begin
                if (row_load && row_last) begin
                    n_state = tcgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcgr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: request handshake and memory controls
    always_comb begin
        i_req.ready = 1'b0;
        cell_we     = 1'b0;
        cell_waddr  = req_cell_idx;
        cell_wdata  = {i_req.attribute, i_req.char_code};
        cell_re     = 1'b0;
        font_we     = 1'b0;
        font_re     = 1'b0;
        font_raddr  = {r_ch, tcgr_pkg::FONT_ROW_W'(0)};
        n_row       = r_row + 1'b1;
        unique case (r_state)
            tcgr_pkg::ST_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = r_clr_addr;
                cell_wdata = tcgr_pkg::CELL_RESET;
            end
            tcgr_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (req_fire) begin
                    case (req_cmd)
                        tcgr_pkg::CMD_LOAD_FONT:  font_we = 1'b1;
                        tcgr_pkg::CMD_WRITE_CELL: cell_we = in_range;
                        tcgr_pkg::CMD_RENDER:     cell_re = in_range;
                        default: ;
                    endcase
                end
            end
            tcgr_pkg::ST_CELL: ;
            tcgr_pkg::ST_BASE: begin
                // fetch the first glyph row
                font_re = 1'b1;
            end
            tcgr_pkg::ST_ROW: begin
                // fetch the following row as this one moves to the result register
                font_re    = row_load;
                font_raddr = {r_ch, tcgr_pkg::FONT_ROW_W'(n_row)};
            end
            default: ;
        endcase
    end

    tcgr_ram #(
        .WIDTH (tcgr_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (cell_re),
        .i_raddr (req_cell_idx),
        .o_rdata (cell_rdata)
    );

    tcgr_ram #(
        .WIDTH (tcgr_pkg::FONT_BYTE_W),
        .DEPTH (tcgr_pkg::FONT_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (i_req.font_address),
        .i_wdata (i_req.font_byte),
        .i_re    (font_re),
        .i_raddr (font_raddr),
        .o_rdata (font_rdata)
    );

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= tcgr_pkg::MODE_32BPP;
            r_frame_base <= '0;
            r_line_bytes <= 16'd2560;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_screen_w   <= 13'd640;
            r_screen_h   <= 13'd400;
        end else if (i_cfg_we) begin
            unique case (tcgr_pkg::t_cfg_idx'(i_cfg_index))
                tcgr_pkg::CFG_DEPTH_MODE: r_mode       <= tcgr_pkg::t_depth'(i_cfg_wdata[1:0]);
                tcgr_pkg::CFG_FRAME_BASE: r_frame_base <= i_cfg_wdata;
                tcgr_pkg::CFG_LINE_BYTES: r_line_bytes <= i_cfg_wdata[15:0];
                tcgr_pkg::CFG_ORIGIN_X:   r_origin_x   <= i_cfg_wdata[11:0];
                tcgr_pkg::CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_wdata[11:0];
                tcgr_pkg::CFG_SCREEN_W:   r_screen_w   <= i_cfg_wdata[12:0];
                tcgr_pkg::CFG_SCREEN_H:   r_screen_h   <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcgr_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tcgr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (row_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Render datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tcgr_pkg::ST_IDLE: begin
                // hold the cell's top-left pixel position
                r_y  <= req_y0;
                r_px <= req_px;
            end
            tcgr_pkg::ST_CELL: begin
                r_ch   <= cell_rdata[7:0];
                r_fore <= tcgr_pkg::pack_colour(r_mode, cell_rdata[11:8]);
                r_back <= tcgr_pkg::pack_colour(r_mode, {1'b0, cell_rdata[14:12]});
                r_prod <= tcgr_pkg::PROD_W'(r_y * r_line_bytes);
            end
            tcgr_pkg::ST_BASE: begin
                r_addr    <= r_frame_base + 32'(r_prod) + px_bytes;
                r_row     <= '0;
                r_colmask <= colmask;
            end
            tcgr_pkg::ST_ROW: begin
                if (row_load) begin
                    // advance one framebuffer line
                    r_addr <= r_addr + 32'(r_line_bytes);
                    r_y    <= r_y + 1'b1;
                    r_row  <= n_row;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (row_load) begin
            r_out_addr <= r_addr;
            r_out_bits <= font_rdata;
            r_out_fore <= r_fore;
            r_out_back <= r_back;
            r_out_last <= row_last;
            if (r_mode inside {tcgr_pkg::MODE_RGB555, tcgr_pkg::MODE_RGB565}) begin
                r_out_mask <= row_visible ? r_colmask : '0;
            end else begin
                r_out_mask <= '1;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.row_address = r_out_addr;
    assign o_res.glyph_bits  = r_out_bits;
    assign o_res.pixel_valid = r_out_mask;
    assign o_res.fore_value  = r_out_fore;
    assign o_res.back_value  = r_out_back;
    assign o_res.last_row    = r_out_last;

endmodule
